/* design/ats_pkg.sv */
// Shared types, constants and digit helpers for the amount-to-spoken-tokens block.
`default_nettype none

package ats_pkg;

  // Field widths
  localparam int unsigned AmountW  = 32;
  localparam int unsigned TokenW   = 5;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned GroupW   = 10;
  localparam int unsigned WholeW   = 26;
  localparam int unsigned WholeLoW = 20;
  localparam int unsigned CentsW   = 7;
  localparam int unsigned SlotW    = 4;

  // Divide by 100 through a reciprocal: floor(x / 100) = (x * Div100Magic) >> Div100Shift
  localparam logic [AmountW-1:0] Div100Magic  = 32'h51EB_851F;
  localparam int unsigned        Div100Shift  = 37;
  // Divide by 1000 for values below 2^20
  localparam logic [20:0]        Div1000Magic = 21'd1073742;
  localparam int unsigned        Div1000Shift = 30;

  localparam logic [WholeW-1:0]  OneMillion   = 26'd1000000;

  localparam int unsigned QueueDepth = 4;

  // Token codes
  localparam logic [TokenW-1:0] TokZero     = 5'd0;
  localparam logic [TokenW-1:0] TokOne      = 5'd1;
  localparam logic [TokenW-1:0] TokTeen     = 5'd10;
  localparam logic [TokenW-1:0] TokTens     = 5'd20;
  localparam logic [TokenW-1:0] TokHundred  = 5'd28;
  localparam logic [TokenW-1:0] TokThousand = 5'd29;
  localparam logic [TokenW-1:0] TokMillion  = 5'd30;
  localparam logic [TokenW-1:0] TokDot      = 5'd31;

  // Token positions of one amount, in spoken order
  typedef enum logic [SlotW-1:0] {
    SlotMilDig,
    SlotMillion,
    SlotThouHund,
    SlotThouHundWord,
    SlotThouTens,
    SlotThouOnes,
    SlotThousand,
    SlotUnitHund,
    SlotUnitHundWord,
    SlotUnitTens,
    SlotUnitOnes,
    SlotZero,
    SlotDot,
    SlotCentsTens,
    SlotCentsOnes
  } slot_e;

  localparam int unsigned NumSlots = 15;

  typedef struct packed {
    logic [DigitW-1:0] hund;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] ones;
  } digits_t;

  // One classified amount, handed from front to back
  typedef struct packed {
    logic                ovf;
    logic [NumSlots-1:0] mask;
    digits_t             thou;
    digits_t             unit;
    logic [DigitW-1:0]   cents_tens;
    logic [DigitW-1:0]   cents_ones;
  } job_t;

  // Split a value below 1000 into decimal digits with small reciprocal multiplies.
  function automatic digits_t split_group(input logic [GroupW-1:0] g);
    logic [15:0] hund_prod;
    logic [9:0]  rem_full;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [6:0]  ones_full;
    digits_t     d;
    hund_prod = 16'(g) * 16'd41;
    d.hund    = hund_prod[15:12];
    rem_full  = g - 10'(d.hund) * 10'd100;
    rem       = rem_full[6:0];
    tens_prod = 15'(rem) * 15'd205;
    d.tens    = tens_prod[14:11];
    ones_full = rem - 7'(d.tens) * 7'd10;
    d.ones    = ones_full[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/amount_to_spoken_tokens_top.sv */
// Top level of the amount-to-spoken-tokens block: front pipeline, job queue, token sequencer.
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  ----------------------------------
//   input     in         push / full           amount_cents_i[31:0]
//   result    out        empty / pop           token_o[4:0], last_o, overflow_o
//
// An amount enters every cycle while full is low; the front is a three-stage
// pipeline (divide by 100, divide by 1000, digit split) feeding a four-entry job queue.
// The back speaks one token per cycle while the output is not stalled, so an amount
// costs 1 to 12 tokens there; the token count of the amount sets the sustained rate.
// A pushed amount passes front stages, queue and sequencer into the output register.
// Reset is asynchronous and active low; it empties every stage, the queue and the output.
// A stalled pop holds the output register; the sequencer, queue and front fill up behind it.
`default_nettype none

module amount_to_spoken_tokens_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [ats_pkg::AmountW-1:0] amount_cents_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ats_pkg::TokenW-1:0]  token_o,
  output logic                        last_o,
  output logic                        overflow_o
);

  // Front to queue
  logic          fq_valid, fq_full;
  ats_pkg::job_t fq_job;
  // Queue to back
  logic          qb_empty, qb_pop;
  ats_pkg::job_t qb_job;

  // Classify the amount: groups, digits and the mask of tokens to say
  ats_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .amount_cents_i (amount_cents_i),
    .job_valid_o    (fq_valid),
    .job_o          (fq_job),
    .job_full_i     (fq_full)
  );

  // Decouple the two sides so a long token run does not stall intake at once
  ats_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_valid),
    .full_o  (fq_full),
    .data_i  (fq_job),
    .pop_i   (qb_pop),
    .empty_o (qb_empty),
    .data_o  (qb_job)
  );

  // Walk the mask, one token per cycle while the output is free, into the output register
  ats_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!qb_empty),
    .job_i       (qb_job),
    .job_pop_o   (qb_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .token_o     (token_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

/* design/ats_front.sv */
// Front pipeline: split the amount into groups and digits and build the token mask.
`default_nettype none

module ats_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [ats_pkg::AmountW-1:0]  amount_cents_i,
  output logic                         job_valid_o,
  output ats_pkg::job_t                job_o,
  input  logic                         job_full_i
);

  logic s1_v_q, s2_v_q, s3_v_q;
  logic adv1, adv2, adv3;
  logic accept;

  assign adv3   = !s3_v_q || !job_full_i;
  assign adv2   = !s2_v_q || adv3;
  assign adv1   = !s1_v_q || adv2;
  assign full_o = !adv1;
  assign accept = push_i && adv1;

  // Stage 1: reciprocal multiply for the whole part
  logic [63:0]                   div_prod;
  logic [ats_pkg::WholeW-1:0]    s1_whole_q;
  logic [ats_pkg::CentsW-1:0]    s1_amt_lo_q;

  assign div_prod = 64'(amount_cents_i) * 64'(ats_pkg::Div100Magic);

  // Stage 2: cents, range flags and thousands quotient
  logic [13:0]                   cents_prod;
  logic [ats_pkg::CentsW-1:0]    cents_d;
  logic [ats_pkg::WholeLoW-1:0]  whole_lo;
  logic [40:0]                   thou_prod;
  logic [ats_pkg::CentsW-1:0]    s2_cents_q;
  logic                          s2_ovf_q, s2_mil_q, s2_zero_q;
  logic [ats_pkg::WholeLoW-1:0]  s2_whole_q;
  logic [ats_pkg::GroupW-1:0]    s2_thou_q;

  assign cents_prod = 14'(s1_whole_q[ats_pkg::CentsW-1:0]) * 14'd100;
  assign cents_d    = s1_amt_lo_q - cents_prod[ats_pkg::CentsW-1:0];
  assign whole_lo   = s1_whole_q[ats_pkg::WholeLoW-1:0];
  assign thou_prod  = 41'(whole_lo) * 41'(ats_pkg::Div1000Magic);

  // Stage 3: unit group and digit split of thousands and cents
  logic [19:0]                   unit_prod;
  logic [ats_pkg::GroupW-1:0]    unit_d;
  ats_pkg::digits_t              thou_dig_d, cents_dig_d;
  logic                          s3_ovf_q, s3_mil_q, s3_zero_q;
  logic [ats_pkg::GroupW-1:0]    s3_unit_q;
  ats_pkg::digits_t              s3_thou_q;
  logic [ats_pkg::DigitW-1:0]    s3_ct_q, s3_co_q;

  assign unit_prod   = 20'(s2_thou_q) * 20'd1000;
  assign unit_d      = s2_whole_q[ats_pkg::GroupW-1:0] - unit_prod[ats_pkg::GroupW-1:0];
  // One million leaves no thousands to speak
  assign thou_dig_d  = s2_mil_q ? '0 : ats_pkg::split_group(s2_thou_q);
  assign cents_dig_d = ats_pkg::split_group(ats_pkg::GroupW'(s2_cents_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= accept;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_whole_q  <= div_prod[ats_pkg::Div100Shift +: ats_pkg::WholeW];
      s1_amt_lo_q <= amount_cents_i[ats_pkg::CentsW-1:0];
    end
    if (adv2) begin
      s2_cents_q <= cents_d;
      s2_ovf_q   <= s1_whole_q > ats_pkg::OneMillion;
      s2_mil_q   <= s1_whole_q == ats_pkg::OneMillion;
      s2_zero_q  <= s1_whole_q == '0;
      s2_whole_q <= whole_lo;
      s2_thou_q  <= thou_prod[ats_pkg::Div1000Shift +: ats_pkg::GroupW];
    end
    if (adv3) begin
      s3_ovf_q  <= s2_ovf_q;
      s3_mil_q  <= s2_mil_q;
      s3_zero_q <= s2_zero_q;
      s3_unit_q <= unit_d;
      s3_thou_q <= thou_dig_d;
      s3_ct_q   <= cents_dig_d.tens;
      s3_co_q   <= cents_dig_d.ones;
    end
  end

  // Queue write side: unit digits and token mask
  ats_pkg::digits_t              unit_dig;
  logic [ats_pkg::NumSlots-1:0]  mask;
  logic                          thou_nz, cents_nz;

  assign unit_dig = ats_pkg::split_group(s3_unit_q);
  assign thou_nz  = |s3_thou_q;
  assign cents_nz = (s3_ct_q != '0) || (s3_co_q != '0);

  always_comb begin
    mask = '0;
    if (s3_ovf_q) begin
      mask[ats_pkg::SlotZero] = 1'b1;
    end else begin
      mask[ats_pkg::SlotMilDig]       = s3_mil_q;
      mask[ats_pkg::SlotMillion]      = s3_mil_q;
      mask[ats_pkg::SlotThouHund]     = s3_thou_q.hund != '0;
      mask[ats_pkg::SlotThouHundWord] = s3_thou_q.hund != '0;
      mask[ats_pkg::SlotThouTens]     = (s3_thou_q.tens != '0) || (s3_thou_q.ones != '0);
      mask[ats_pkg::SlotThouOnes]     = (s3_thou_q.tens > 4'd1) && (s3_thou_q.ones != '0);
      mask[ats_pkg::SlotThousand]     = thou_nz;
      mask[ats_pkg::SlotUnitHund]     = unit_dig.hund != '0;
      mask[ats_pkg::SlotUnitHundWord] = unit_dig.hund != '0;
      mask[ats_pkg::SlotUnitTens]     = (unit_dig.tens != '0) || (unit_dig.ones != '0);
      mask[ats_pkg::SlotUnitOnes]     = (unit_dig.tens > 4'd1) && (unit_dig.ones != '0);
      mask[ats_pkg::SlotZero]         = s3_zero_q;
      mask[ats_pkg::SlotDot]          = cents_nz;
      mask[ats_pkg::SlotCentsTens]    = cents_nz;
      mask[ats_pkg::SlotCentsOnes]    = s3_co_q != '0;
    end
  end

  assign job_valid_o      = s3_v_q;
  assign job_o.ovf        = s3_ovf_q;
  assign job_o.mask       = mask;
  assign job_o.thou       = s3_thou_q;
  assign job_o.unit       = unit_dig;
  assign job_o.cents_tens = s3_ct_q;
  assign job_o.cents_ones = s3_co_q;

`ifndef SYNTHESIS
  a_full_means_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (s1_v_q && s2_v_q && s3_v_q && job_full_i))
    else $error("front reports full with a free stage");
`endif

endmodule

`default_nettype wire

/* design/ats_queue.sv */
// Short job queue between front and back.
`default_nettype none

module ats_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ats_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output ats_pkg::job_t data_o
);

  localparam int unsigned PtrW = $clog2(ats_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(ats_pkg::QueueDepth + 1);

  ats_pkg::job_t    mem_q [ats_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(ats_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(ats_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(ats_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ats_pkg::QueueDepth))
    else $error("queue count past depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("back popped an empty queue");
`endif

endmodule

`default_nettype wire

/* design/ats_back.sv */
// Back end: walk a job's token mask, one token per cycle when output is free.
`default_nettype none

module ats_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  ats_pkg::job_t               job_i,
  output logic                        job_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [ats_pkg::TokenW-1:0]  token_o,
  output logic                        last_o,
  output logic                        overflow_o
);

  // Token for the tens position of a group: teen, tens word or lone ones digit
  function automatic logic [ats_pkg::TokenW-1:0] tens_token(input ats_pkg::digits_t d);
    logic [ats_pkg::TokenW-1:0] t;
    if (d.tens == 4'd1) begin
      t = ats_pkg::TokTeen + ats_pkg::TokenW'(d.ones);
    end else if (d.tens != '0) begin
      t = ats_pkg::TokTens + ats_pkg::TokenW'(d.tens) - 5'd2;
    end else begin
      t = ats_pkg::TokenW'(d.ones);
    end
    return t;
  endfunction

  logic                          cur_v_q, out_v_q;
  ats_pkg::job_t                 cur_q;
  logic [ats_pkg::TokenW-1:0]    tok_q;
  logic                          last_q, ovf_q;

  logic                          out_free, emit, last_tok, take;
  logic [ats_pkg::NumSlots-1:0]  pick, rest;
  ats_pkg::slot_e                slot;
  logic [ats_pkg::TokenW-1:0]    tok;

  assign out_free  = !out_v_q || pop_i;
  assign emit      = cur_v_q && out_free;
  // Lowest pending slot speaks next
  assign pick      = cur_q.mask & (~cur_q.mask + ats_pkg::NumSlots'(1));
  assign rest      = cur_q.mask & ~pick;
  assign last_tok  = rest == '0;
  assign take      = job_valid_i && (!cur_v_q || (emit && last_tok));
  assign job_pop_o = take;

  always_comb begin
    slot = ats_pkg::SlotMilDig;
    for (int i = 0; i < ats_pkg::NumSlots; i++) begin
      if (pick[i]) slot = ats_pkg::slot_e'(ats_pkg::SlotW'(i));
    end
  end

  always_comb begin
    unique case (slot)
      ats_pkg::SlotMilDig:       tok = ats_pkg::TokOne;
      ats_pkg::SlotMillion:      tok = ats_pkg::TokMillion;
      ats_pkg::SlotThouHund:     tok = ats_pkg::TokenW'(cur_q.thou.hund);
      ats_pkg::SlotThouHundWord: tok = ats_pkg::TokHundred;
      ats_pkg::SlotThouTens:     tok = tens_token(cur_q.thou);
      ats_pkg::SlotThouOnes:     tok = ats_pkg::TokenW'(cur_q.thou.ones);
      ats_pkg::SlotThousand:     tok = ats_pkg::TokThousand;
      ats_pkg::SlotUnitHund:     tok = ats_pkg::TokenW'(cur_q.unit.hund);
      ats_pkg::SlotUnitHundWord: tok = ats_pkg::TokHundred;
      ats_pkg::SlotUnitTens:     tok = tens_token(cur_q.unit);
      ats_pkg::SlotUnitOnes:     tok = ats_pkg::TokenW'(cur_q.unit.ones);
      ats_pkg::SlotZero:         tok = ats_pkg::TokZero;
      ats_pkg::SlotDot:          tok = ats_pkg::TokDot;
      ats_pkg::SlotCentsTens:    tok = ats_pkg::TokenW'(cur_q.cents_tens);
      ats_pkg::SlotCentsOnes:    tok = ats_pkg::TokenW'(cur_q.cents_ones);
      default:                   tok = ats_pkg::TokZero;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take) begin
        cur_v_q <= 1'b1;
      end else if (emit && last_tok) begin
        cur_v_q <= 1'b0;
      end
      if (out_free) out_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= job_i;
    end else if (emit) begin
      cur_q.mask <= rest;
    end
    if (emit) begin
      tok_q  <= tok;
      last_q <= last_tok;
      ovf_q  <= cur_q.ovf;
    end
  end

  assign empty_o    = !out_v_q;
  assign token_o    = tok_q;
  assign last_o     = last_q;
  assign overflow_o = ovf_q;

`ifndef SYNTHESIS
  a_mask_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (cur_q.mask != '0))
    else $error("active job with nothing left to speak");
  a_ovf_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && ovf_q) |-> (last_q && (tok_q == ats_pkg::TokZero)))
    else $error("overflow result is not a lone zero token");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_tok && !job_valid_i) |=> !cur_v_q)
    else $error("job still active after its last token");
`endif

endmodule

`default_nettype wire
